/* sv/char_literal_escape_decoder_unit_defines.svh */
// assertion macros for the checker of the escape decoder
`ifndef CHAR_LITERAL_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define CHAR_LITERAL_ESCAPE_DECODER_UNIT_DEFINES_SVH

// generic concurrent assertion with explicit clock and active-low reset
`define CLED_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// same, on the block clock and reset
`define CLED_ASSERT_BLK(lbl, prop, msg) \
	`CLED_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

/* sv/cled_pkg.sv */
package cled_pkg;

	// one input transaction
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty_req;
	} in_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] value;
		logic       invalid;
	} out_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_BSL  = 2'd1,
		KIND_HEX  = 2'd2,
		KIND_OCT  = 2'd3
	} kind_t;

	// decoder state carried between bytes of one literal
	typedef struct packed {
		logic [1:0] pos;
		kind_t      kind;
		logic [5:0] acc;
		logic       settled;
		logic [7:0] sval;
		logic       sinv;
	} st_t;

	localparam st_t ST_RESET = '{pos: 2'd0, kind: KIND_NONE, acc: 6'd0,
		settled: 1'b0, sval: 8'd0, sinv: 1'b0};

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	localparam logic [1:0] POS_FIRST_DIG  = 2'd2;
	localparam logic [1:0] POS_SECOND_DIG = 2'd3;
	localparam logic [1:0] POS_AFTER_BSL  = 2'd1;

endpackage

/* sv/char_literal_escape_decoder_unit.sv */
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------
// input    | in_valid, in_stall | in_data  : ch, last, empty_req
// output   | out_valid,out_stall| out_data : value, invalid
//
// one byte per cycle sustained while in_stall is low; out_valid rises after the
// transaction carrying last or empty_req is taken and has passed the input register,
// then the result register
// the decode step between the two registers is a few byte compares and muxes
// arst_n clears valid flags and decoder state; payload registers are not reset
// in_stall rises only while the result register is full and out_stall is high
// and the byte in the input register would produce a result
module char_literal_escape_decoder_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cled_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output cled_pkg::out_t  out_data
);
	import cled_pkg::*;

	// input register stage
	in_t  item_s1;
	logic vld_s1;

	// decoder state across bytes of one literal
	st_t  st_q;
	st_t  st_nxt;

	// result register
	out_t res_q;
	logic res_vld_q;

	logic has_res;
	out_t res;
	logic res_free;
	logic s1_go;
	logic s1_take;

	cled_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.st_nxt  (st_nxt),
		.has_res (has_res),
		.res     (res)
	);

	// result register can load when empty or being drained this cycle
	assign res_free = !res_vld_q || !out_stall;
	// the byte in stage 1 retires unless it has a result with nowhere to go
	assign s1_go    = !has_res || res_free;
	assign in_stall = vld_s1 && !s1_go;
	assign s1_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s1_take ? 1'b1 : (vld_s1 && !s1_go);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			item_s1 <= in_data;
		end
	end

	// state advances once per retired byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (vld_s1 && s1_go) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_free) begin
			res_vld_q <= vld_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && vld_s1 && has_res) begin
			res_q <= res;
		end
	end

	assign out_valid = res_vld_q;
	assign out_data  = res_q;

endmodule

/* sv/cled_step.sv */
module cled_step (
	input  cled_pkg::st_t  st,
	input  cled_pkg::in_t  item,
	output cled_pkg::st_t  st_nxt,
	output logic           has_res,
	output cled_pkg::out_t res
);
	import cled_pkg::*;

	logic       hex_ok;
	logic [3:0] hex_d;
	logic       oct_ok;
	logic [2:0] oct_d;
	logic [8:0] full;
	st_t        t;
	logic [7:0] c;

	// named escapes a b f n r t v, anything else maps to itself
	function automatic logic [7:0] named_esc(input logic [7:0] x);
		logic [7:0] r;
		begin
			case (x)
				8'h61: r = 8'd7;
				8'h62: r = 8'd8;
				8'h66: r = 8'd12;
				8'h6E: r = 8'd10;
				8'h72: r = 8'd13;
				8'h74: r = 8'd9;
				8'h76: r = 8'd11;
				default: r = x;
			endcase
			return r;
		end
	endfunction

	assign c = item.ch;

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			hex_d = c[3:0];
		end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
			hex_d = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			hex_ok = 1'b0;
		end
		oct_ok = (c >= CH_ZERO && c <= CH_SEVEN);
		oct_d  = c[2:0];
		full   = {st.acc, oct_d};
	end

	// one byte of the literal
	always_comb begin
		t = st;
		if (!st.settled) begin
			unique case (st.kind)
				KIND_NONE: begin
					if (c != CH_BSL) begin
						t.settled = 1'b1;
						t.sval    = c;
					end else begin
						t.kind = KIND_BSL;
						t.pos  = POS_AFTER_BSL;
					end
				end
				KIND_BSL: begin
					if (c == CH_X) begin
						t.kind = KIND_HEX;
						t.pos  = POS_FIRST_DIG;
					end else if (c >= CH_EIGHT && c <= CH_NINE) begin
						t.settled = 1'b1;
						t.sval    = c;
					end else if (oct_ok) begin
						t.kind = KIND_OCT;
						t.acc  = {3'd0, oct_d};
						t.pos  = POS_FIRST_DIG;
					end else if (c == CH_NUL) begin
						t.settled = 1'b1;
						t.sinv    = 1'b1;
					end else begin
						t.settled = 1'b1;
						t.sval    = named_esc(c);
					end
				end
				KIND_HEX: begin
					t.settled = 1'b1;
					if (st.pos == POS_FIRST_DIG) begin
						if (!hex_ok) begin
							t.sinv = 1'b1;
						end else begin
							t.settled = 1'b0;
							t.acc     = {2'd0, hex_d};
							t.pos     = POS_SECOND_DIG;
						end
					end else if (!hex_ok) begin
						t.sval = {4'd0, st.acc[3:0]};
					end else begin
						t.sval = {st.acc[3:0], hex_d};
					end
				end
				KIND_OCT: begin
					t.settled = 1'b1;
					if (!oct_ok) begin
						t.sval = {2'd0, st.acc};
					end else if (st.pos == POS_FIRST_DIG) begin
						t.settled = 1'b0;
						t.acc     = {st.acc[2:0], oct_d};
						t.pos     = POS_SECOND_DIG;
					end else if (full[8]) begin
						t.sinv = 1'b1;
					end else begin
						t.sval = full[7:0];
					end
				end
				default: t = st;
			endcase
		end
	end

	// close the literal on last or empty
	always_comb begin
		has_res = item.empty_req | item.last;
		res     = '{value: 8'd0, invalid: 1'b1};
		if (!item.empty_req) begin
			if (t.settled) begin
				res = '{value: t.sinv ? 8'd0 : t.sval, invalid: t.sinv};
			end else if (t.kind == KIND_HEX && t.pos == POS_SECOND_DIG) begin
				res = '{value: {4'd0, t.acc[3:0]}, invalid: 1'b0};
			end else if (t.kind == KIND_OCT) begin
				res = '{value: {2'd0, t.acc}, invalid: 1'b0};
			end
		end
		st_nxt = has_res ? ST_RESET : t;
	end

endmodule

/* sv/cled_checker.sv */
`include "char_literal_escape_decoder_unit_defines.svh"

module cled_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input cled_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input cled_pkg::out_t out_data
);
	import cled_pkg::*;

	logic in_acc_end;

	assign in_acc_end = in_valid && !in_stall && (in_data.last || in_data.empty_req);

	// a stalled result transaction holds
	`CLED_ASSERT_BLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

	// an invalid result carries a zero value
	`CLED_ASSERT_BLK(a_inv_zero, out_valid && out_data.invalid |-> out_data.value == 8'd0, "invalid result with nonzero value")

	// input backpressure only when the result side is full and stalled
	`CLED_ASSERT_BLK(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")

	// a fresh result follows a closing input transaction, through the input and result registers
	`CLED_ASSERT_BLK(a_res_origin, $rose(out_valid) |-> $past(in_acc_end, 2), "result without closing input")

endmodule

bind char_literal_escape_decoder_unit cled_checker u_cled_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
